### rtl/anpr_pkg.sv
package anpr_pkg;

    // Width of the value field on the result channel.
    localparam int VALUE_OUT_W = 32;

    // Parser phase codes.
    localparam logic [2:0] PH_START     = 3'd0;
    localparam logic [2:0] PH_ZERO      = 3'd1;
    localparam logic [2:0] PH_HEX_FIRST = 3'd2;
    localparam logic [2:0] PH_BIN_FIRST = 3'd3;
    localparam logic [2:0] PH_HEX       = 3'd4;
    localparam logic [2:0] PH_BIN       = 3'd5;
    localparam logic [2:0] PH_DEC       = 3'd6;
    localparam logic [2:0] PH_ERR       = 3'd7;

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_0   = 8'h30;
    localparam logic [7:0] CH_1   = 8'h31;
    localparam logic [7:0] CH_9   = 8'h39;
    localparam logic [7:0] CH_UA  = 8'h41;
    localparam logic [7:0] CH_UB  = 8'h42;
    localparam logic [7:0] CH_UF  = 8'h46;
    localparam logic [7:0] CH_UX  = 8'h58;
    localparam logic [7:0] CH_LA  = 8'h61;
    localparam logic [7:0] CH_LB  = 8'h62;
    localparam logic [7:0] CH_LF  = 8'h66;
    localparam logic [7:0] CH_LX  = 8'h78;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } digit_t;

    function automatic digit_t dec_digit(input logic [7:0] c);
        digit_t d;
        d.ok  = (c >= CH_0) && (c <= CH_9);
        d.val = 4'(c - CH_0);
        return d;
    endfunction

    function automatic digit_t hex_digit(input logic [7:0] c);
        digit_t d;
        if ((c >= CH_0) && (c <= CH_9))
        begin
            d.ok  = 1'b1;
            d.val = 4'(c - CH_0);
        end
        else if ((c >= CH_LA) && (c <= CH_LF))
        begin
            d.ok  = 1'b1;
            d.val = 4'(c - CH_LA + 8'd10);
        end
        else if ((c >= CH_UA) && (c <= CH_UF))
        begin
            d.ok  = 1'b1;
            d.val = 4'(c - CH_UA + 8'd10);
        end
        else
        begin
            d.ok  = 1'b0;
            d.val = 4'd0;
        end
        return d;
    endfunction

endpackage

### rtl/ascii_number_parser_with_radix_prefix.sv
// A terminator item's result is registered in the result register, or in the skid entry while that is held.
// Throughput: one character item per cycle while in_stall is low; the accumulator update is a single
//   shift-add step done in the accept cycle.
// A two-entry output stage (result register plus skid) keeps input moving while a result waits.
// Reset (rst_n low, asynchronous): start-of-string phase, accumulator zero, no result pending.
module ascii_number_parser_with_radix_prefix #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [7:0]                        char_in,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [anpr_pkg::VALUE_OUT_W-1:0]  value,
    output logic                              parse_error
);
    import anpr_pkg::*;

    // Parser state
    logic [VALUE_WIDTH-1:0] acc_reg, acc_next;
    logic [2:0]             phase_reg, phase_next;
    logic                   error_reg, error_next;

    // Output register and skid entry
    logic                   out_valid_reg;
    logic [VALUE_OUT_W-1:0] out_value_reg;
    logic                   out_error_reg;
    logic                   skid_valid_reg;
    logic [VALUE_OUT_W-1:0] skid_value_reg;
    logic                   skid_error_reg;

    logic                   accept;
    logic                   is_term;
    logic                   emit;
    logic                   res_error;
    logic [VALUE_OUT_W-1:0] res_value;
    logic                   main_free;

    digit_t                 dd;
    digit_t                 hd;
    logic [VALUE_WIDTH-1:0] acc_dec;
    logic [VALUE_WIDTH-1:0] acc_hex;
    logic [VALUE_WIDTH-1:0] acc_bin;

    // The skid entry only fills when the result register is held, so input
    // stops only once two results are waiting.
    assign in_stall  = skid_valid_reg;
    assign accept    = in_valid && !in_stall;
    assign is_term   = (char_in == CH_NUL);
    assign emit      = accept && is_term;
    assign main_free = !out_valid_reg || !out_stall;

    assign out_valid   = out_valid_reg;
    assign value       = out_value_reg;
    assign parse_error = out_error_reg;

    assign dd = dec_digit(char_in);
    assign hd = hex_digit(char_in);

    // acc * radix + digit, as shifts with adds (decimal) or an OR (hex, binary); wraps at VALUE_WIDTH.
    assign acc_dec = (acc_reg << 3) + (acc_reg << 1) + VALUE_WIDTH'(dd.val);
    assign acc_hex = (acc_reg << 4) | VALUE_WIDTH'(hd.val);
    assign acc_bin = (acc_reg << 1) | VALUE_WIDTH'(char_in == CH_1);

    // An empty prefix counts as an error at the terminator.
    assign res_error = error_reg || (phase_reg == PH_HEX_FIRST) || (phase_reg == PH_BIN_FIRST);
    assign res_value = res_error ? '0 : VALUE_OUT_W'(acc_reg);

    always_comb
    begin
        acc_next   = acc_reg;
        phase_next = phase_reg;
        error_next = error_reg;
        if (accept)
        begin
            if (is_term)
            begin
                acc_next   = '0;
                phase_next = PH_START;
                error_next = 1'b0;
            end
            else
            begin
                unique case (phase_reg)
                    PH_START:
                    begin
                        if (char_in == CH_0)
                            phase_next = PH_ZERO;
                        else if (dd.ok)
                        begin
                            acc_next   = acc_dec;
                            phase_next = PH_DEC;
                        end
                        else
                        begin
                            phase_next = PH_ERR;
                            error_next = 1'b1;
                        end
                    end
                    PH_ZERO:
                    begin
                        if ((char_in == CH_LX) || (char_in == CH_UX))
                            phase_next = PH_HEX_FIRST;
                        else if ((char_in == CH_LB) || (char_in == CH_UB))
                            phase_next = PH_BIN_FIRST;
                        else if (dd.ok)
                        begin
                            acc_next   = acc_dec;
                            phase_next = PH_DEC;
                        end
                        else
                        begin
                            phase_next = PH_ERR;
                            error_next = 1'b1;
                        end
                    end
                    PH_HEX_FIRST, PH_HEX:
                    begin
                        if (hd.ok)
                        begin
                            acc_next   = acc_hex;
                            phase_next = PH_HEX;
                        end
                        else
                        begin
                            phase_next = PH_ERR;
                            error_next = 1'b1;
                        end
                    end
                    PH_BIN_FIRST, PH_BIN:
                    begin
                        if ((char_in == CH_0) || (char_in == CH_1))
                        begin
                            acc_next   = acc_bin;
                            phase_next = PH_BIN;
                        end
                        else
                        begin
                            phase_next = PH_ERR;
                            error_next = 1'b1;
                        end
                    end
                    PH_DEC:
                    begin
                        if (dd.ok)
                            acc_next = acc_dec;
                        else
                        begin
                            phase_next = PH_ERR;
                            error_next = 1'b1;
                        end
                    end
                    PH_ERR:
                    begin
                        // rest of the string is dropped
                    end
                    default:
                    begin
                        phase_next = PH_ERR;
                        error_next = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            phase_reg <= PH_START;
            error_reg <= 1'b0;
        end
        else
        begin
            acc_reg   <= acc_next;
            phase_reg <= phase_next;
            error_reg <= error_next;
        end
    end

    // Output stage: result register fed from skid first, then from a new result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (main_free)
            begin
                if (skid_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else
                    out_valid_reg <= emit;
            end
            else if (emit)
                skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (main_free)
        begin
            if (skid_valid_reg)
            begin
                out_value_reg <= skid_value_reg;
                out_error_reg <= skid_error_reg;
            end
            else if (emit)
            begin
                out_value_reg <= res_value;
                out_error_reg <= res_error;
            end
        end
        else if (emit)
        begin
            skid_value_reg <= res_value;
            skid_error_reg <= res_error;
        end
    end

    a_skid_implies_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a result while the result register is empty");

    a_term_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (phase_reg == PH_START) && (acc_reg == '0) && !error_reg)
        else $error("parser did not return to start after a terminator");

    a_error_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && parse_error) |-> (value == '0))
        else $error("error result carries a nonzero value");

    a_error_phase: assert property (@(posedge clk) disable iff (!rst_n)
        error_reg == (phase_reg == PH_ERR))
        else $error("error flag and error phase disagree");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid && $stable(value) && $stable(parse_error))
        else $error("stalled result changed");

endmodule

### tb/tb_ascii_number_parser_with_radix_prefix.sv
`timescale 1ns / 1ps

module tb_ascii_number_parser_with_radix_prefix;

    import anpr_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int VALUE_WIDTH  = 32;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int CHARS_PER_PH = 150;
    localparam int MAX_REPORTS  = 10;

    // ------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------
    logic                    clk         = 1'b0;
    logic                    rst_n       = 1'b0;
    logic                    in_valid    = 1'b0;
    logic                    in_stall;
    logic [7:0]              char_in     = 8'd0;
    logic                    out_valid;
    logic                    out_stall   = 1'b0;
    logic [VALUE_OUT_W-1:0]  value;
    logic                    parse_error;

    always #(CLK_PERIOD / 2) clk = ~clk;

    ascii_number_parser_with_radix_prefix #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .char_in     (char_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .value       (value),
        .parse_error (parse_error)
    );

    // ------------------------------------------------------------------
    // Parser prediction: own copy of accumulator, phase and sticky error
    // ------------------------------------------------------------------
    typedef struct {
        logic [VALUE_OUT_W-1:0] value;
        logic                   parse_error;
    } parse_result_t;

    parse_result_t          expected_results[$];
    logic [7:0]             char_queue[$];

    logic [VALUE_WIDTH-1:0] acc_st   = '0;
    logic [2:0]             phase_st = PH_START;
    logic                   err_st   = 1'b0;

    int                     idle_pct  = 0;
    int                     stall_pct = 0;
    int                     cycle_count = 0;
    int                     error_count = 0;

    // Digit value of c, legal only when below the radix (so 'a' fails in
    // decimal and '2' fails in binary).
    function automatic bit digit_of(input logic [7:0] c, input int unsigned radix,
                                    output logic [3:0] d);
        d = 4'd0;
        if (c >= CH_0 && c <= CH_9)
            d = 4'(c - CH_0);
        else if (c >= CH_LA && c <= CH_LF)
            d = 4'(c - CH_LA + 8'd10);
        else if (c >= CH_UA && c <= CH_UF)
            d = 4'(c - CH_UA + 8'd10);
        else
            return 1'b0;
        return (d < radix);
    endfunction

    function automatic void shift_digit(input int unsigned radix, input logic [3:0] d);
        logic [VALUE_WIDTH-1:0] r;
        r      = VALUE_WIDTH'(radix);
        acc_st = acc_st * r + VALUE_WIDTH'(d);
    endfunction

    function automatic void mark_bad();
        err_st   = 1'b1;
        phase_st = PH_ERR;
    endfunction

    // Advance the parser by one accepted character; a terminator queues the
    // expected result and returns to the start of a string.
    function automatic void parse_char(input logic [7:0] c);
        parse_result_t r;
        logic [3:0]    d;
        if (c == CH_NUL)
        begin
            // A prefix with no digit behind it counts as an error.
            if (phase_st == PH_HEX_FIRST || phase_st == PH_BIN_FIRST)
                err_st = 1'b1;
            r.value       = err_st ? '0 : VALUE_OUT_W'(acc_st);
            r.parse_error = err_st;
            expected_results.push_back(r);
            acc_st   = '0;
            phase_st = PH_START;
            err_st   = 1'b0;
            return;
        end
        case (phase_st)
            PH_START:
            begin
                if (c == CH_0)
                    phase_st = PH_ZERO;
                else if (digit_of(c, 10, d))
                begin
                    shift_digit(10, d);
                    phase_st = PH_DEC;
                end
                else
                    mark_bad();
            end
            PH_ZERO:
            begin
                if (c == CH_LX || c == CH_UX)
                    phase_st = PH_HEX_FIRST;
                else if (c == CH_LB || c == CH_UB)
                    phase_st = PH_BIN_FIRST;
                else if (digit_of(c, 10, d))
                begin
                    // leading zero then decimal digits stays decimal
                    shift_digit(10, d);
                    phase_st = PH_DEC;
                end
                else
                    mark_bad();
            end
            PH_HEX_FIRST, PH_HEX:
            begin
                if (digit_of(c, 16, d))
                begin
                    shift_digit(16, d);
                    phase_st = PH_HEX;
                end
                else
                    mark_bad();
            end
            PH_BIN_FIRST, PH_BIN:
            begin
                if (digit_of(c, 2, d))
                begin
                    shift_digit(2, d);
                    phase_st = PH_BIN;
                end
                else
                    mark_bad();
            end
            PH_DEC:
            begin
                if (digit_of(c, 10, d))
                    shift_digit(10, d);
                else
                    mark_bad();
            end
            default:
            begin
                // error phase: swallow everything up to the terminator
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Input driver: presents the next queued character, holds it while
    // stalled, and idles at random between items.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            char_in  <= 8'd0;
        end
        else
        begin
            if (in_valid && !in_stall)
                parse_char(char_in);
            if (!in_valid || !in_stall)
            begin
                if (char_queue.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    in_valid <= 1'b1;
                    char_in  <= char_queue.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: random back-pressure, then compare each accepted
    // result against the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        parse_result_t e;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("[%0t] unexpected result: value=%h parse_error=%b",
                                 $realtime, value, parse_error);
                end
                else
                begin
                    e = expected_results.pop_front();
                    if (value !== e.value || parse_error !== e.parse_error)
                    begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                        begin
                            $display("[%0t] mismatch: expected value=%h parse_error=%b,",
                                     $realtime, e.value, e.parse_error);
                            $display("    got value=%h parse_error=%b",
                                     value, parse_error);
                        end
                    end
                end
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++)
            char_queue.push_back(s[i]);
        char_queue.push_back(CH_NUL);
    endtask

    function automatic logic [7:0] any_hex_char();
        int h;
        h = $urandom_range(21);
        if (h < 10)
            return CH_0 + 8'(h);
        else if (h < 16)
            return CH_LA + 8'(h - 10);
        else
            return CH_UA + 8'(h - 16);
    endfunction

    // Digit count: mostly short, sometimes long enough to wrap the accumulator.
    function automatic int digit_count(input int lo, input int typical, input int longest);
        if ($urandom_range(9) == 0)
            return $urandom_range(longest, lo);
        return $urandom_range(typical, lo);
    endfunction

    // One random string plus terminator; returns how many items it queued.
    function automatic int queue_random_string();
        logic [7:0] s[$];
        int         kind;
        int         n;
        kind = $urandom_range(99);
        if (kind < 90)
        begin
            // well-formed number, optionally broken further down
            case ($urandom_range(2))
                0:
                begin
                    n = digit_count(1, 10, 25);
                    repeat (n)
                        s.push_back(CH_0 + 8'($urandom_range(9)));
                end
                1:
                begin
                    s.push_back(CH_0);
                    s.push_back($urandom_range(1) ? CH_LX : CH_UX);
                    n = digit_count(0, 8, 20);
                    repeat (n)
                        s.push_back(any_hex_char());
                end
                default:
                begin
                    s.push_back(CH_0);
                    s.push_back($urandom_range(1) ? CH_LB : CH_UB);
                    n = digit_count(0, 16, 40);
                    repeat (n)
                        s.push_back(CH_0 + 8'($urandom_range(1)));
                end
            endcase
            // broken sequences: a stray character somewhere, then up to three more hex characters
            if (kind >= 70)
            begin
                s.insert($urandom_range(s.size()), 8'($urandom_range(255, 1)));
                repeat ($urandom_range(3))
                    s.push_back(any_hex_char());
            end
        end
        else
        begin
            // pure noise, any nonzero byte
            repeat ($urandom_range(8, 1))
                s.push_back(8'($urandom_range(255, 1)));
        end
        foreach (s[i])
            char_queue.push_back(s[i]);
        char_queue.push_back(CH_NUL);
        return s.size() + 1;
    endfunction

    task automatic wait_drained();
        while (char_queue.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
    endtask

    // Watchdog
    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin : main_seq
        int n;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty string, lone zero, empty prefixes, mixed-case hex,
        // binary, leading zero decimal, bad hex letter, error then junk.
        queue_text("");
        queue_text("0");
        queue_text("0x");
        queue_text("0B");
        queue_text("0XaF");
        queue_text("0b10");
        queue_text("09");
        queue_text("0xg1");
        queue_text("z1");

        // Random phases: no idling, sender idle, receiver stalling, both.
        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 77; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 77; end
                default: begin idle_pct = 19; stall_pct = 19; end
            endcase
            n = 0;
            while (n < CHARS_PER_PH)
                n += queue_random_string();
            wait_drained();
        end

        repeat (10) @(posedge clk);

        if (error_count == 0 && expected_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### filelist.f
rtl/anpr_pkg.sv
rtl/ascii_number_parser_with_radix_prefix.sv
tb/tb_ascii_number_parser_with_radix_prefix.sv
